/* hdl/sfc_pkg.sv */
package sfc_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int NUM_PLANES = 6;

  localparam int LANE_W     = 16;
  localparam int ROW_W      = 4 * LANE_W;
  localparam int CENTER_W   = 3 * LANE_W;
  localparam int DIAM_W     = 15;
  localparam int PLANE_W    = 4 * LANE_W;
  localparam int CFG_IDX_W  = 3;

  // Full-width products and sums: nothing saturates.
  localparam int PROD_W     = 2 * LANE_W;
  localparam int CTR_W      = PROD_W + 2;
  localparam int PP_W       = LANE_W + CTR_W;
  localparam int DOT_W      = PP_W + 2;
  localparam int CMP_W      = DOT_W + 1;

  // Squared column length and the radicand of the square root.
  localparam int S_W        = 2 * LANE_W;
  localparam int XW         = S_W + 2 * FRAC_BITS;
  localparam int ROOT_CELLS = XW / 2;
  localparam int LEN_W      = ROOT_CELLS;
  localparam int RAD_W      = LEN_W + DIAM_W;

  typedef logic [PLANE_W-1:0] planes_t [NUM_PLANES];

  typedef struct packed {
    logic [3:0][ROW_W-1:0] rows;
    logic [CENTER_W-1:0]   center;
    logic [DIAM_W-1:0]     diam;
    logic                  skip;
  } obj_t;

  // One slot of the root chain: partial square root plus the object's sideband.
  typedef struct packed {
    logic                    valid;
    logic [XW-1:0]           rem;
    logic [XW-1:0]           root;
    logic [XW-1:0]           probe;
    logic signed [DOT_W-1:0] min_dot;
    logic [DIAM_W-1:0]       diam;
  } cell_t;

endpackage

/* hdl/sfc_in_if.sv */
interface sfc_in_if;
  logic                           valid;
  logic                           ready;
  logic [sfc_pkg::ROW_W-1:0]      model_row0;
  logic [sfc_pkg::ROW_W-1:0]      model_row1;
  logic [sfc_pkg::ROW_W-1:0]      model_row2;
  logic [sfc_pkg::ROW_W-1:0]      model_row3;
  logic [sfc_pkg::CENTER_W-1:0]   center_xyz;
  logic [sfc_pkg::DIAM_W-1:0]     box_diameter;
  logic                           skip_depth_planes;

  modport source (
    output valid, model_row0, model_row1, model_row2, model_row3,
    output center_xyz, box_diameter, skip_depth_planes,
    input  ready
  );
  modport sink (
    input  valid, model_row0, model_row1, model_row2, model_row3,
    input  center_xyz, box_diameter, skip_depth_planes,
    output ready
  );
endinterface

/* hdl/sfc_out_if.sv */
interface sfc_out_if;
  logic valid;
  logic ready;
  logic culled;

  modport source (output valid, culled, input ready);
  modport sink (input valid, culled, output ready);
endinterface

/* hdl/sfc_cfg_if.sv */
interface sfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sfc_pkg::CFG_IDX_W-1:0]   index;
  logic [sfc_pkg::PLANE_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/sphere_frustum_cull.sv */
// Pipeline from an accepted transaction to its result: six front stages, one root
// cell per result bit, radius multiply, output register.
// Throughput: one object per cycle; each stage holds only while its successor is full.
// Reset (rst_n, synchronous, active low) empties the pipeline and clears all six planes.
module sphere_frustum_cull (
  input  logic       clk,
  input  logic       rst_n,
  sfc_in_if.sink     in_chan,
  sfc_out_if.source  out_chan,
  sfc_cfg_if.sink    cfg_chan
);

  sfc_pkg::planes_t              planes_r;
  sfc_pkg::obj_t                 obj;
  sfc_pkg::cell_t                link [sfc_pkg::ROOT_CELLS+1];
  logic [sfc_pkg::ROOT_CELLS:0]  rdy;
  logic                          in_rdy;

  assign cfg_chan.ready = 1'b1;

  // Drop writes beyond the plane list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
        planes_r[p] <= '0;
      end
    end else if (cfg_chan.valid &&
                 (cfg_chan.index < sfc_pkg::CFG_IDX_W'(sfc_pkg::NUM_PLANES))) begin
      planes_r[cfg_chan.index] <= cfg_chan.data;
    end
  end

  always_comb begin
    obj.rows[0] = in_chan.model_row0;
    obj.rows[1] = in_chan.model_row1;
    obj.rows[2] = in_chan.model_row2;
    obj.rows[3] = in_chan.model_row3;
    obj.center  = in_chan.center_xyz;
    obj.diam    = in_chan.box_diameter;
    obj.skip    = in_chan.skip_depth_planes;
  end

  assign in_chan.ready = in_rdy;

  sfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_rdy),
    .obj      (obj),
    .planes   (planes_r),
    .cell_o   (link[0]),
    .rdy_i    (rdy[0])
  );

  for (genvar g = 0; g < sfc_pkg::ROOT_CELLS; g++) begin : g_root
    sfc_root_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_i (link[g]),
      .rdy_o  (rdy[g]),
      .cell_o (link[g+1]),
      .rdy_i  (rdy[g+1])
    );
  end

  sfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_i     (link[sfc_pkg::ROOT_CELLS]),
    .rdy_o      (rdy[sfc_pkg::ROOT_CELLS]),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_culled (out_chan.culled)
  );

endmodule

/* hdl/sfc_front.sv */
module sfc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfc_pkg::obj_t    obj,
  input  sfc_pkg::planes_t planes,
  output sfc_pkg::cell_t   cell_o,
  input  logic             rdy_i
);

  localparam int STAGES = 6;

  function automatic logic signed [sfc_pkg::LANE_W-1:0] lane(
    input logic [sfc_pkg::ROW_W-1:0] word, input int k);
    return word[sfc_pkg::LANE_W*k +: sfc_pkg::LANE_W];
  endfunction

  function automatic logic signed [sfc_pkg::DOT_W-1:0] smin(
    input logic signed [sfc_pkg::DOT_W-1:0] a,
    input logic signed [sfc_pkg::DOT_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic [STAGES-1:0] v_r;
  logic [STAGES:0]   en;

  // stage 1: matrix-by-center products and column squares
  logic signed [sfc_pkg::PROD_W-1:0] prod_r [4][4];
  logic signed [sfc_pkg::PROD_W-1:0] prod_nxt [4][4];
  logic [sfc_pkg::S_W-1:0]           sq_r [3];
  logic [sfc_pkg::S_W-1:0]           sq_nxt [3];
  logic [sfc_pkg::DIAM_W-1:0]        diam1_r;
  logic                              skip1_r;
  // stage 2: world center, squared length
  logic signed [sfc_pkg::CTR_W-1:0]  ctr_r [4];
  logic signed [sfc_pkg::CTR_W-1:0]  ctr_nxt [4];
  logic [sfc_pkg::S_W-1:0]           s2_r, s2_nxt;
  logic [sfc_pkg::DIAM_W-1:0]        diam2_r;
  logic                              skip2_r;
  // stage 3: plane-by-center products
  logic signed [sfc_pkg::PP_W-1:0]   pp_r [sfc_pkg::NUM_PLANES][4];
  logic signed [sfc_pkg::PP_W-1:0]   pp_nxt [sfc_pkg::NUM_PLANES][4];
  logic [sfc_pkg::S_W-1:0]           s3_r;
  logic [sfc_pkg::DIAM_W-1:0]        diam3_r;
  logic                              skip3_r;
  // stage 4: dot products
  logic signed [sfc_pkg::DOT_W-1:0]  dot_r [sfc_pkg::NUM_PLANES];
  logic signed [sfc_pkg::DOT_W-1:0]  dot_nxt [sfc_pkg::NUM_PLANES];
  logic [sfc_pkg::S_W-1:0]           s4_r;
  logic [sfc_pkg::DIAM_W-1:0]        diam4_r;
  logic                              skip4_r;
  // stage 5: pairwise minima
  logic signed [sfc_pkg::DOT_W-1:0]  pmin_r [3];
  logic signed [sfc_pkg::DOT_W-1:0]  pmin_nxt [3];
  logic [sfc_pkg::S_W-1:0]           s5_r;
  logic [sfc_pkg::DIAM_W-1:0]        diam5_r;
  // stage 6: minimum over enabled planes
  logic signed [sfc_pkg::DOT_W-1:0]  min6_r, min6_nxt;
  logic [sfc_pkg::S_W-1:0]           s6_r;
  logic [sfc_pkg::DIAM_W-1:0]        diam6_r;

  // A stage takes new data when it is empty or its successor moves.
  always_comb begin
    en[STAGES] = rdy_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[r][j] = lane(obj.rows[r], j) * lane({16'h0, obj.center}, j);
      end
      // homogeneous w is one in fixed point
      prod_nxt[r][3] = sfc_pkg::PROD_W'(lane(obj.rows[r], 3)) <<< sfc_pkg::FRAC_BITS;
    end
    for (int r = 0; r < 3; r++) begin
      sq_nxt[r] = $unsigned(sfc_pkg::PROD_W'(lane(obj.rows[r], 0) * lane(obj.rows[r], 0)));
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      ctr_nxt[r] = prod_r[r][0] + prod_r[r][1] + prod_r[r][2] + prod_r[r][3];
    end
    s2_nxt = sq_r[0] + sq_r[1] + sq_r[2];
  end

  always_comb begin
    for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
      for (int j = 0; j < 4; j++) begin
        pp_nxt[p][j] = lane(planes[p], j) * ctr_r[j];
      end
    end
  end

  always_comb begin
    for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
      dot_nxt[p] = pp_r[p][0] + pp_r[p][1] + pp_r[p][2] + pp_r[p][3];
    end
  end

  // Skipped depth planes are replaced by the left plane, which leaves the minimum unchanged.
  always_comb begin
    pmin_nxt[0] = smin(dot_r[0], dot_r[1]);
    pmin_nxt[1] = smin(dot_r[2], dot_r[3]);
    pmin_nxt[2] = skip4_r ? dot_r[0] : smin(dot_r[4], dot_r[5]);
    min6_nxt    = smin(smin(pmin_r[0], pmin_r[1]), pmin_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r  <= prod_nxt;
      sq_r    <= sq_nxt;
      diam1_r <= obj.diam;
      skip1_r <= obj.skip;
    end
    if (en[1]) begin
      ctr_r   <= ctr_nxt;
      s2_r    <= s2_nxt;
      diam2_r <= diam1_r;
      skip2_r <= skip1_r;
    end
    if (en[2]) begin
      pp_r    <= pp_nxt;
      s3_r    <= s2_r;
      diam3_r <= diam2_r;
      skip3_r <= skip2_r;
    end
    if (en[3]) begin
      dot_r   <= dot_nxt;
      s4_r    <= s3_r;
      diam4_r <= diam3_r;
      skip4_r <= skip3_r;
    end
    if (en[4]) begin
      pmin_r  <= pmin_nxt;
      s5_r    <= s4_r;
      diam5_r <= diam4_r;
    end
    if (en[5]) begin
      min6_r  <= min6_nxt;
      s6_r    <= s5_r;
      diam6_r <= diam5_r;
    end
  end

  always_comb begin
    cell_o.valid   = v_r[STAGES-1];
    cell_o.rem     = sfc_pkg::XW'(s6_r) << (2 * sfc_pkg::FRAC_BITS);
    cell_o.root    = '0;
    cell_o.probe   = sfc_pkg::XW'(1) << (sfc_pkg::XW - 2);
    cell_o.min_dot = min6_r;
    cell_o.diam    = diam6_r;
  end

endmodule

/* hdl/sfc_root_cell.sv */
module sfc_root_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  sfc_pkg::cell_t cell_i,
  output logic           rdy_o,
  output sfc_pkg::cell_t cell_o,
  input  logic           rdy_i
);

  sfc_pkg::cell_t     cell_r, cell_nxt;
  logic [sfc_pkg::XW:0] trial;

  assign rdy_o = !cell_r.valid || rdy_i;

  // One bit of the root: subtract root+probe if it fits, then advance the probe.
  always_comb begin
    cell_nxt = cell_i;
    trial    = {1'b0, cell_i.root} + {1'b0, cell_i.probe};
    if ({1'b0, cell_i.rem} >= trial) begin
      cell_nxt.rem  = cell_i.rem - trial[sfc_pkg::XW-1:0];
      cell_nxt.root = (cell_i.root >> 1) + cell_i.probe;
    end else begin
      cell_nxt.root = cell_i.root >> 1;
    end
    cell_nxt.probe = cell_i.probe >> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (rdy_o) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

/* hdl/sfc_back.sv */
module sfc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sfc_pkg::cell_t cell_i,
  output logic           rdy_o,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_culled
);

  logic                              m_valid_r;
  logic [sfc_pkg::RAD_W-1:0]         rad_r, rad_nxt;
  logic signed [sfc_pkg::DOT_W-1:0]  dot_r;
  logic                              out_valid_r;
  logic                              culled_r, culled_nxt;
  logic                              en_out;
  logic signed [sfc_pkg::CMP_W-1:0]  twice_dot, neg_rad;
  logic [sfc_pkg::LEN_W-1:0]         len;

  assign en_out = !out_valid_r || out_ready;
  assign rdy_o  = !m_valid_r || en_out;

  assign len     = cell_i.root[sfc_pkg::LEN_W-1:0];
  assign rad_nxt = sfc_pkg::RAD_W'(cell_i.diam) * sfc_pkg::RAD_W'(len);

  assign twice_dot  = {dot_r, 1'b0};
  assign neg_rad    = -$signed(sfc_pkg::CMP_W'(rad_r));
  assign culled_nxt = twice_dot < neg_rad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_o) begin
        m_valid_r <= cell_i.valid;
      end
      if (en_out) begin
        out_valid_r <= m_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      rad_r <= rad_nxt;
      dot_r <= cell_i.min_dot;
    end
    if (en_out) begin
      culled_r <= culled_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_culled = culled_r;

endmodule

/* tb/sv/tb_sphere_frustum_cull.sv */
module tb_sphere_frustum_cull;

  typedef enum logic [sfc_pkg::CFG_IDX_W-1:0] {
    PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP, PLANE_NEAR, PLANE_FAR
  } plane_sel_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_CHOKE} sink_mode_t;

  typedef struct {
    int seq;
    bit culled;
  } verdict_t;

  localparam logic [sfc_pkg::ROW_W-1:0] ID_ROW0 = {16'sd0, 16'sd0, 16'sd0, 16'sd256};
  localparam logic [sfc_pkg::ROW_W-1:0] ID_ROW1 = {16'sd0, 16'sd0, 16'sd256, 16'sd0};
  localparam logic [sfc_pkg::ROW_W-1:0] ID_ROW2 = {16'sd0, 16'sd256, 16'sd0, 16'sd0};
  localparam logic [sfc_pkg::ROW_W-1:0] ID_ROW3 = {16'sd256, 16'sd0, 16'sd0, 16'sd0};
  localparam int DRAIN_CYCLES = 48;

  logic clk;
  logic rst_n;

  sfc_in_if  in_bus();
  sfc_out_if out_bus();
  sfc_cfg_if cfg_bus();

  sphere_frustum_cull dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  sfc_pkg::planes_t frustum;
  sfc_pkg::planes_t frustum_next;
  sfc_pkg::obj_t    objects_to_send[$];
  verdict_t         verdicts_due[$];
  int               errors = 0;
  int               accepted = 0;
  bit               in_taken = 1'b0;
  int               burst_left = 0;
  int               gap_left = 0;
  sink_mode_t       sink_mode = SINK_OPEN;
  int               sink_left = 0;
  int               sink_tick = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic flag_error(input string what);
    $display("ERROR @%0t: %s", $time, what);
    errors++;
  endtask

  function automatic logic [sfc_pkg::PLANE_W-1:0] quad(input logic signed [15:0] a, b, c, d);
    return {d, c, b, a};
  endfunction

  function automatic logic signed [15:0] rs(input int lo, input int hi);
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic sfc_pkg::obj_t make_obj(input logic [sfc_pkg::ROW_W-1:0] r0, r1, r2, r3,
                                             input logic signed [15:0] x, y, z,
                                             input logic [sfc_pkg::DIAM_W-1:0] diam,
                                             input logic skip);
    sfc_pkg::obj_t o;
    o.rows[0] = r0;
    o.rows[1] = r1;
    o.rows[2] = r2;
    o.rows[3] = r3;
    o.center  = {z, y, x};
    o.diam    = diam;
    o.skip    = skip;
    return o;
  endfunction

  function automatic sfc_pkg::obj_t ident_at(input logic signed [15:0] x, y, z,
                                             input logic [sfc_pkg::DIAM_W-1:0] diam,
                                             input logic skip);
    return make_obj(ID_ROW0, ID_ROW1, ID_ROW2, ID_ROW3, x, y, z, diam, skip);
  endfunction

  // Scaled, slightly sheared and translated object placed around the box frustum.
  function automatic sfc_pkg::obj_t scene_obj();
    logic signed [15:0]          sc [3];
    logic [sfc_pkg::ROW_W-1:0]   r3;
    logic [sfc_pkg::DIAM_W-1:0]  dm;
    for (int k = 0; k < 3; k++) begin
      sc[k] = rs(48, 512);
      if ($urandom_range(0, 7) == 0) sc[k] = -sc[k];
    end
    if ($urandom_range(0, 9) == 0) r3 = quad(rs(-64, 64), rs(-64, 64), rs(-64, 64), rs(128, 384));
    else r3 = ID_ROW3;
    if ($urandom_range(0, 15) == 0) dm = sfc_pkg::DIAM_W'($urandom_range(0, 32767));
    else dm = sfc_pkg::DIAM_W'($urandom_range(0, 700));
    return make_obj(quad(sc[0], rs(-96, 96), rs(-96, 96), rs(-1024, 1024)),
                    quad(rs(-96, 96), sc[1], rs(-96, 96), rs(-1024, 1024)),
                    quad(rs(-96, 96), rs(-96, 96), sc[2], rs(-1024, 1024)),
                    r3, rs(-1800, 1800), rs(-1800, 1800), rs(-1800, 1800),
                    dm, 1'($urandom_range(0, 1)));
  endfunction

  function automatic bit cull_verdict(input sfc_pkg::obj_t o);
    longint m [4][4];
    longint v [4];
    longint c [4];
    longint sq, dot, rad2;
    longint unsigned radicand, root, trial;
    bit hit;
    hit = 1'b0;
    for (int r = 0; r < 4; r++)
      for (int j = 0; j < 4; j++)
        m[r][j] = longint'($signed(o.rows[r][16*j +: 16]));
    v[0] = longint'($signed(o.center[15:0]));
    v[1] = longint'($signed(o.center[31:16]));
    v[2] = longint'($signed(o.center[47:32]));
    v[3] = longint'(1) << sfc_pkg::FRAC_BITS;
    for (int r = 0; r < 4; r++) begin
      c[r] = 0;
      for (int j = 0; j < 4; j++) c[r] += m[r][j] * v[j];
    end
    // Column length at doubled scale, truncated: bitwise floor square root.
    sq = m[0][0] * m[0][0] + m[1][0] * m[1][0] + m[2][0] * m[2][0];
    radicand = sq;
    radicand = radicand << (2 * sfc_pkg::FRAC_BITS);
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    rad2 = longint'(o.diam) * longint'(root);
    for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
      if (o.skip && (p == PLANE_NEAR || p == PLANE_FAR)) continue;
      dot = 0;
      for (int j = 0; j < 4; j++) dot += longint'($signed(frustum[p][16*j +: 16])) * c[j];
      if (2 * dot < -rad2) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic program_planes();
    for (int i = 0; i < sfc_pkg::NUM_PLANES; i++) begin
      @(negedge clk);
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= plane_sel_t'(i);
      cfg_bus.data  <= frustum_next[i];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
      frustum[i] = frustum_next[i];
    end
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Axis-aligned box of half-width 4.0 around the origin.
  task automatic load_box_frustum();
    frustum_next[PLANE_LEFT]   = quad(256, 0, 0, 1024);
    frustum_next[PLANE_RIGHT]  = quad(-256, 0, 0, 1024);
    frustum_next[PLANE_BOTTOM] = quad(0, 256, 0, 1024);
    frustum_next[PLANE_TOP]    = quad(0, -256, 0, 1024);
    frustum_next[PLANE_NEAR]   = quad(0, 0, 256, 1024);
    frustum_next[PLANE_FAR]    = quad(0, 0, -256, 1024);
    program_planes();
  endtask

  task automatic queue_random(input int n);
    sfc_pkg::obj_t o;
    int            pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        o = scene_obj();
      end else if (pick < 85) begin
        o = make_obj({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, rs(-32768, 32767), rs(-32768, 32767),
                     rs(-32768, 32767), sfc_pkg::DIAM_W'($urandom_range(0, 32767)),
                     1'($urandom_range(0, 1)));
      end else begin
        o = scene_obj();
        case ($urandom_range(0, 3))
          0: o.rows[$urandom_range(0, 3)] = {$urandom, $urandom};
          1: begin
            o.rows[0][15:0] = '0;
            o.rows[1][15:0] = '0;
            o.rows[2][15:0] = '0;
          end
          2: o.rows[3] = '0;
          default: o.center = {rs(-32768, 32767), rs(-32768, 32767), rs(-32768, 32767)};
        endcase
      end
      objects_to_send.push_back(o);
    end
  endtask

  task automatic drain_pipeline();
    while (objects_to_send.size() != 0 || verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: record accepted transactions and predict their verdict.
  always @(posedge clk) begin
    in_taken = rst_n && in_bus.valid && in_bus.ready;
    if (in_taken) begin
      verdicts_due.push_back('{accepted, cull_verdict(objects_to_send[0])});
      void'(objects_to_send.pop_front());
      accepted++;
    end
  end

  // Driver: present objects in bursts; hold until the transaction completes.
  always @(negedge clk) begin
    if (!(in_bus.valid && !in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (!rst_n || objects_to_send.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else begin
        in_bus.valid             <= 1'b1;
        in_bus.model_row0        <= objects_to_send[0].rows[0];
        in_bus.model_row1        <= objects_to_send[0].rows[1];
        in_bus.model_row2        <= objects_to_send[0].rows[2];
        in_bus.model_row3        <= objects_to_send[0].rows[3];
        in_bus.center_xyz        <= objects_to_send[0].center;
        in_bus.box_diameter      <= objects_to_send[0].diam;
        in_bus.skip_depth_planes <= objects_to_send[0].skip;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver back-pressure: switch between stall patterns at random.
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(50, 300);
    end else begin
      sink_left--;
    end
    sink_tick++;
    case (sink_mode)
      SINK_OPEN:     out_bus.ready <= 1'b1;
      SINK_COIN:     out_bus.ready <= 1'($urandom_range(0, 1));
      SINK_PERIODIC: out_bus.ready <= (sink_tick % 8) < 5;
      default:       out_bus.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (verdicts_due.size() == 0) begin
        flag_error($sformatf("culled=%0b with no object outstanding", out_bus.culled));
      end else begin
        v = verdicts_due.pop_front();
        if (out_bus.culled !== v.culled)
          flag_error($sformatf("object %0d: culled=%0b, predicted %0b",
                               v.seq, out_bus.culled, v.culled));
      end
    end
  end

  initial begin
    rst_n                    = 1'b0;
    in_bus.valid             = 1'b0;
    in_bus.model_row0        = '0;
    in_bus.model_row1        = '0;
    in_bus.model_row2        = '0;
    in_bus.model_row3        = '0;
    in_bus.center_xyz        = '0;
    in_bus.box_diameter      = '0;
    in_bus.skip_depth_planes = 1'b0;
    out_bus.ready            = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.index            = PLANE_LEFT;
    cfg_bus.data             = '0;
    for (int i = 0; i < sfc_pkg::NUM_PLANES; i++) frustum[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Planes still cleared: nothing may be culled.
    objects_to_send.push_back(ident_at(0, 0, 0, 0, 0));
    objects_to_send.push_back(make_obj({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                                       {4{16'h8000}}, 16'sh8000, 16'sh8000, 16'sh8000,
                                       15'h7FFF, 1'b0));
    objects_to_send.push_back(scene_obj());
    drain_pipeline();

    load_box_frustum();
    objects_to_send.push_back(ident_at(0, 0, 0, 0, 0));
    // Zero radius: on the plane survives, just behind it is dropped.
    objects_to_send.push_back(ident_at(-1024, 0, 0, 0, 0));
    objects_to_send.push_back(ident_at(-1025, 0, 0, 0, 0));
    objects_to_send.push_back(ident_at(-1025, 0, 0, 1, 0));
    objects_to_send.push_back(ident_at(-1025, 0, 0, 2, 0));
    objects_to_send.push_back(ident_at(1030, 0, 0, 12, 0));
    objects_to_send.push_back(ident_at(1030, 0, 0, 11, 0));
    objects_to_send.push_back(ident_at(0, 1200, 0, 0, 0));
    objects_to_send.push_back(ident_at(0, 0, 1025, 0, 0));
    objects_to_send.push_back(ident_at(0, 0, 1025, 0, 1));
    objects_to_send.push_back(ident_at(0, 0, -1500, 0, 1));
    objects_to_send.push_back(ident_at(0, 0, -1500, 0, 0));
    // Zero first column: radius collapses even at the widest diameter.
    objects_to_send.push_back(make_obj('0, ID_ROW1, ID_ROW2, ID_ROW3, 0, 2000, 0,
                                       15'h7FFF, 1'b0));
    // Zero w row: the planes' constant term drops out.
    objects_to_send.push_back(make_obj(ID_ROW0, ID_ROW1, ID_ROW2, '0, -1500, 0, 0, 0, 0));
    objects_to_send.push_back(make_obj(ID_ROW0, ID_ROW1, ID_ROW2, '0, 0, 0, 0, 0, 0));
    objects_to_send.push_back(make_obj({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
                                       {4{16'h7FFF}}, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                       15'h7FFF, 1'b1));
    objects_to_send.push_back(make_obj({4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}},
                                       {4{16'hFFFF}}, -1, -1, -1, 0, 1'b0));
    objects_to_send.push_back(make_obj(quad(16'sh8000, 0, 0, 0), '0, '0, ID_ROW3,
                                       -1800, 0, 0, 15'h7FFF, 1'b0));
    objects_to_send.push_back(make_obj('0, '0, '0, '0, 0, 0, 0, 0, 1'b1));
    queue_random(450);
    drain_pipeline();

    // Box planes tilted and shifted at random.
    frustum_next[PLANE_LEFT]   = quad(rs(200, 300), rs(-40, 40), rs(-40, 40), rs(200, 2000));
    frustum_next[PLANE_RIGHT]  = quad(rs(-300, -200), rs(-40, 40), rs(-40, 40), rs(200, 2000));
    frustum_next[PLANE_BOTTOM] = quad(rs(-40, 40), rs(200, 300), rs(-40, 40), rs(200, 2000));
    frustum_next[PLANE_TOP]    = quad(rs(-40, 40), rs(-300, -200), rs(-40, 40), rs(200, 2000));
    frustum_next[PLANE_NEAR]   = quad(rs(-40, 40), rs(-40, 40), rs(200, 300), rs(200, 2000));
    frustum_next[PLANE_FAR]    = quad(rs(-40, 40), rs(-40, 40), rs(-300, -200), rs(200, 2000));
    program_planes();
    queue_random(350);
    drain_pipeline();

    for (int i = 0; i < sfc_pkg::NUM_PLANES; i++) frustum_next[i] = {4{16'h7FFF}};
    program_planes();
    queue_random(150);
    drain_pipeline();

    for (int i = 0; i < sfc_pkg::NUM_PLANES; i++) frustum_next[i] = {4{16'h8000}};
    program_planes();
    queue_random(150);
    drain_pipeline();

    for (int i = 0; i < sfc_pkg::NUM_PLANES; i++) frustum_next[i] = {$urandom, $urandom};
    program_planes();
    queue_random(200);
    drain_pipeline();

    load_box_frustum();
    queue_random(450);
    drain_pipeline();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
